[rtl/core/pjas_pkg.sv]
// Package for the print job aging scheduler: shared types, constants and
// the control and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pjas_pkg;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam logic [7:0] TPP_RESET = 8'd10;
	localparam logic [7:0] PENALTY_RESET = 8'd3;
	localparam logic [15:0] SLACK_RESET = 16'd15;

	localparam logic [1:0] REG_TPP = 2'd0;
	localparam logic [1:0] REG_PENALTY = 2'd1;
	localparam logic [1:0] REG_SLACK = 2'd2;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0] pages;
		logic [3:0] computer;
		logic signed [31:0] prio;
	} entry_t;

	typedef enum logic [1:0] {
		RES_ACCEPT,
		RES_FULL,
		RES_PRINT,
		RES_TICK
	} res_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_INSERT,
		ST_DIV,
		ST_POP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul2;
		logic rd_walk;
		logic shift;
		logic insert;
		logic dec;
		logic div_step;
		logic rd_head;
		logic pop;
		logic emit;
		res_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic tl_nz;
		logic idx_zero;
		logic stop;
		logic div_last;
	} dp_status_t;

	// Saturate a 35-bit signed value to signed 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

[rtl/core/pjas_ifs.sv]
// Channel interfaces of the print job aging scheduler: job request input,
// result output and configuration write. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface pjas_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [3:0] job_computer;
	logic [7:0] job_pages;
	modport source(output valid, command, job_computer, job_pages, input ready);
	modport sink(input valid, command, job_computer, job_pages, output ready);
endinterface

interface pjas_out_if;
	logic valid;
	logic ready;
	logic accepted;
	logic [15:0] assigned_id;
	logic queue_full;
	logic done_valid;
	logic [15:0] done_id;
	logic started_valid;
	logic [15:0] started_id;
	logic [3:0] started_computer;
	logic printing;
	logic [7:0] page_number;
	logic [7:0] current_pages;
	logic [4:0] queue_count;
	modport source(output valid, accepted, assigned_id, queue_full, done_valid, done_id,
		started_valid, started_id, started_computer, printing, page_number,
		current_pages, queue_count, input ready);
	modport sink(input valid, accepted, assigned_id, queue_full, done_valid, done_id,
		started_valid, started_id, started_computer, printing, page_number,
		current_pages, queue_count, output ready);
endinterface

interface pjas_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/pjas_ctrl.sv]
// Controller state machine of the print job aging scheduler.
// Uses pjas_pkg; drives the datapath by command struct and reads its status.
`timescale 1ns / 1ps
`default_nettype none
module pjas_ctrl
	import pjas_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_command,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire dp_status_t status,
	output dp_cmd_t cmd
);
	state_t state_q, state_d;
	res_kind_t kind_q, kind_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= RES_ACCEPT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		cmd = '0;
		cmd.kind = kind_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_command == CMD_SUBMIT) begin
						if (status.full) begin
							kind_d = RES_FULL;
							state_d = ST_EMIT;
						end else begin
							state_d = ST_MUL;
						end
					end else if (status.tl_nz) begin
						cmd.dec = 1'b1;
						state_d = ST_DIV;
					end else begin
						cmd.rd_head = 1'b1;
						state_d = ST_POP;
					end
				end
			end
			ST_MUL: begin
				cmd.mul2 = 1'b1;
				state_d = ST_WALK_RD;
			end
			ST_WALK_RD: begin
				if (status.idx_zero) begin
					state_d = ST_INSERT;
				end else begin
					cmd.rd_walk = 1'b1;
					state_d = ST_WALK_CMP;
				end
			end
			ST_WALK_CMP: begin
				if (status.stop) begin
					state_d = ST_INSERT;
				end else begin
					cmd.shift = 1'b1;
					state_d = ST_WALK_RD;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				kind_d = RES_ACCEPT;
				state_d = ST_EMIT;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					kind_d = RES_PRINT;
					state_d = ST_EMIT;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				kind_d = RES_TICK;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/pjas_dp.sv]
// Datapath of the print job aging scheduler: configuration registers, queue
// memory, insertion walk, printer state, page divider and result register. Uses pjas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pjas_dp
	import pjas_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic [3:0] in_computer,
	input wire logic [7:0] in_pages,
	input wire dp_cmd_t cmd,
	output dp_status_t status,
	output logic res_accepted,
	output logic [15:0] res_assigned_id,
	output logic res_queue_full,
	output logic res_done_valid,
	output logic [15:0] res_done_id,
	output logic res_started_valid,
	output logic [15:0] res_started_id,
	output logic [3:0] res_started_computer,
	output logic res_printing,
	output logic [7:0] res_page_number,
	output logic [7:0] res_current_pages,
	output logic [4:0] res_queue_count
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = 8 + CW;

	logic [7:0] tpp_q, penalty_q;
	logic [15:0] slack_q;

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q, idx_q;

	logic [3:0] comp_q;
	logic [7:0] pages_q;
	logic [15:0] prod1_q;
	logic signed [31:0] np_q;
	logic [SW-1:0] slip_q;
	logic [15:0] last_id_q, next_id;

	logic [15:0] cur_id_q, tl_q, done_id_q;
	logic [7:0] cur_pages_q;
	logic [3:0] cur_comp_q;
	logic done_v_q, start_v_q;

	logic [7:0] rem_q, divisor;
	logic [15:0] dvd_q, quo_q;
	logic [3:0] dcnt_q;
	logic [8:0] dtrial;
	logic dge;

	logic signed [33:0] thr;
	logic signed [34:0] aged_wide, np_slip;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [7:0] page_val;

	// Map a logical queue position onto a physical slot of the ring.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [CW-1:0] off);
		logic [CW:0] s;
		s = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, off};
		if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
			s = s - (CW + 1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpp_q <= TPP_RESET;
			penalty_q <= PENALTY_RESET;
			slack_q <= SLACK_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TPP: tpp_q <= cfg_data[7:0];
				REG_PENALTY: penalty_q <= cfg_data[7:0];
				REG_SLACK: slack_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign next_id = (last_id_q == 16'hffff) ? 16'd1 : last_id_q + 16'd1;
	assign thr = 34'(np_q) + $signed({18'b0, slack_q});
	assign aged_wide = ($signed({np_q[31], np_q, 1'b0}) <<< 0)
		- 35'(rd_q.prio);
	assign np_slip = 35'(np_q) + $signed({{(35 - SW){1'b0}}, slip_q});
	assign rd_addr = cmd.rd_head ? head_q : phys(head_q, idx_q - CW'(1));
	assign wr_addr = phys(head_q, idx_q);

	assign divisor = (tpp_q == 8'd0) ? 8'd1 : tpp_q;
	assign dtrial = {rem_q, dvd_q[15]};
	assign dge = dtrial >= {1'b0, divisor};
	assign page_val = (quo_q >= 16'd255) ? 8'd255 : quo_q[7:0] + 8'd1;

	assign status.full = cnt_q == CW'(QUEUE_DEPTH);
	assign status.tl_nz = tl_q != 16'd0;
	assign status.idx_zero = idx_q == '0;
	assign status.stop = 34'(rd_q.prio) <= thr;
	assign status.div_last = dcnt_q == 4'd15;

	// Queue memory: one read and one write port, read data registered.
	always_ff @(posedge clk) begin
		if (cmd.rd_walk || cmd.rd_head) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.shift) begin
			mem[wr_addr] <= '{id: rd_q.id, pages: rd_q.pages, computer: rd_q.computer,
				prio: sat32(aged_wide)};
		end else if (cmd.insert) begin
			mem[wr_addr] <= '{id: next_id, pages: pages_q, computer: comp_q, prio: np_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			comp_q <= in_computer;
			pages_q <= in_pages;
			prod1_q <= 16'(in_pages * penalty_q);
		end
		if (cmd.mul2) begin
			np_q <= $signed({8'b0, 24'(prod1_q * tpp_q)});
			slip_q <= SW'(penalty_q);
			idx_q <= cnt_q;
		end else if (cmd.shift) begin
			np_q <= sat32(np_slip);
			slip_q <= slip_q + SW'(penalty_q);
			idx_q <= idx_q - CW'(1);
		end
		if (cmd.dec) begin
			rem_q <= 8'd0;
			dvd_q <= tl_q - 16'd1;
			dcnt_q <= 4'd0;
		end else if (cmd.div_step) begin
			rem_q <= dge ? 8'(dtrial - {1'b0, divisor}) : dtrial[7:0];
			dvd_q <= {dvd_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], dge};
			dcnt_q <= dcnt_q + 4'd1;
		end
		if (cmd.pop) begin
			done_id_q <= cur_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q <= '0;
			last_id_q <= 16'd0;
			cur_id_q <= 16'd0;
			cur_pages_q <= 8'd0;
			cur_comp_q <= 4'd0;
			tl_q <= 16'd0;
			done_v_q <= 1'b0;
			start_v_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				cnt_q <= cnt_q + CW'(1);
				last_id_q <= next_id;
			end
			if (cmd.dec) begin
				tl_q <= tl_q - 16'd1;
			end
			if (cmd.pop) begin
				done_v_q <= cur_id_q != 16'd0;
				start_v_q <= cnt_q != '0;
				if (cnt_q != '0) begin
					cur_id_q <= rd_q.id;
					cur_pages_q <= rd_q.pages;
					cur_comp_q <= rd_q.computer;
					tl_q <= 16'(rd_q.pages * tpp_q);
					cnt_q <= cnt_q - CW'(1);
					head_q <= phys(head_q, CW'(1));
				end else begin
					cur_id_q <= 16'd0;
				end
			end
		end
	end

	// Result register, loaded when the controller hands a result over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_accepted <= 1'b0;
			res_assigned_id <= 16'd0;
			res_queue_full <= 1'b0;
			res_done_valid <= 1'b0;
			res_done_id <= 16'd0;
			res_started_valid <= 1'b0;
			res_started_id <= 16'd0;
			res_started_computer <= 4'd0;
			res_printing <= 1'b0;
			res_page_number <= 8'd0;
			res_current_pages <= 8'd0;
			res_queue_count <= 5'd0;
		end else if (cmd.emit) begin
			res_accepted <= cmd.kind == RES_ACCEPT;
			res_assigned_id <= (cmd.kind == RES_ACCEPT) ? last_id_q : 16'd0;
			res_queue_full <= cmd.kind == RES_FULL;
			res_done_valid <= (cmd.kind == RES_TICK) && done_v_q;
			res_done_id <= ((cmd.kind == RES_TICK) && done_v_q) ? done_id_q : 16'd0;
			res_started_valid <= (cmd.kind == RES_TICK) && start_v_q;
			res_started_id <= ((cmd.kind == RES_TICK) && start_v_q) ? cur_id_q : 16'd0;
			res_started_computer <= ((cmd.kind == RES_TICK) && start_v_q) ? cur_comp_q : 4'd0;
			res_printing <= cmd.kind == RES_PRINT;
			res_page_number <= (cmd.kind == RES_PRINT) ? page_val : 8'd0;
			res_current_pages <= (cmd.kind == RES_PRINT) ? cur_pages_q : 8'd0;
			res_queue_count <= 5'(cnt_q);
		end
	end
endmodule
`default_nettype wire

[rtl/core/print_job_aging_scheduler_unit.sv]
// Print job aging scheduler, top level: a controller state machine and a
// datapath. Depends on pjas_pkg, pjas_ifs, pjas_ctrl and pjas_dp.
`timescale 1ns / 1ps
`default_nettype none
// Each request gives exactly one result. A submit runs the multiply step, then the insertion
// walk over queued entries from the tail until it reaches the head or stops at an entry that
// is not above, then the insert and emit steps; each passed entry costs one memory read and
// one aged write-back on the queue memory's read and write ports. A tick that counts a job
// down runs the bit-serial page divider (one quotient bit a cycle) before its result; a tick
// that finishes or starts a job passes a pop step, and a rejected submit goes straight to its
// result. Configuration writes are always taken and must arrive only while the block is idle.
// The queue memory needs no clearing after reset.
module print_job_aging_scheduler_unit
	import pjas_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pjas_in_if.sink in_ch,
	pjas_out_if.source out_ch,
	pjas_cfg_if.sink cfg
);
	dp_cmd_t cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	pjas_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_command(in_ch.command),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.status(status),
		.cmd(cmd)
	);

	pjas_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data(cfg.data),
		.in_computer(in_ch.job_computer),
		.in_pages(in_ch.job_pages),
		.cmd(cmd),
		.status(status),
		.res_accepted(out_ch.accepted),
		.res_assigned_id(out_ch.assigned_id),
		.res_queue_full(out_ch.queue_full),
		.res_done_valid(out_ch.done_valid),
		.res_done_id(out_ch.done_id),
		.res_started_valid(out_ch.started_valid),
		.res_started_id(out_ch.started_id),
		.res_started_computer(out_ch.started_computer),
		.res_printing(out_ch.printing),
		.res_page_number(out_ch.page_number),
		.res_current_pages(out_ch.current_pages),
		.res_queue_count(out_ch.queue_count)
	);
endmodule
`default_nettype wire

[tb/pjas_tb_ifs_note.sv]
// Holds the queue-entry and result types used by the scheduler checker for its own queue copy.
// Depends on nothing; the channel interfaces come from the RTL interface file.
`timescale 1ns / 1ps
package pjas_tb_pkg;
	typedef struct {
		logic [15:0] id;
		logic [7:0] pages;
		logic [3:0] computer;
		longint prio;
	} job_slot_t;

	typedef struct packed {
		logic accepted;
		logic [15:0] assigned_id;
		logic queue_full;
		logic done_valid;
		logic [15:0] done_id;
		logic started_valid;
		logic [15:0] started_id;
		logic [3:0] started_computer;
		logic printing;
		logic [7:0] page_number;
		logic [7:0] current_pages;
		logic [4:0] queue_count;
	} sched_result_t;
endpackage

[tb/pjas_checker.sv]
// Scheduler checker: watches the request, result and register channels, keeps its own
// copy of the job queue and printer, and compares each result. Depends on pjas_pkg and pjas_tb_pkg.
`timescale 1ns / 1ps
module pjas_checker
	import pjas_pkg::*;
	import pjas_tb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	pjas_in_if in_ch,
	pjas_out_if out_ch,
	pjas_cfg_if cfg,
	output int fail_count,
	output int pending
);
	job_slot_t jobs[$];
	sched_result_t due_results[$];
	logic [15:0] cur_id, ticks_left, last_id;
	logic [7:0] cur_pages;
	logic [3:0] cur_computer;
	logic [7:0] tpp, penalty;
	logic [15:0] slack;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	task automatic schedule_request(logic cmd, logic [3:0] comp, logic [7:0] pages);
		sched_result_t r;
		job_slot_t slot;
		longint np, slip;
		int pos, i;
		int unsigned pg, dv;
		r = '{default: '0};
		if (cmd == CMD_SUBMIT) begin
			if (jobs.size() >= 16) begin
				r.queue_full = 1'b1;
			end else begin
				last_id = (last_id == 16'hffff) ? 16'd1 : last_id + 16'd1;
				np = longint'(pages) * longint'(penalty) * longint'(tpp);
				slip = penalty;
				pos = 0;
				for (i = jobs.size(); i > 0; i--) begin
					if (jobs[i-1].prio <= np + longint'(slack)) begin
						pos = i;
						break;
					end
					jobs[i-1].prio = clamp32(2 * np - jobs[i-1].prio);
					np = clamp32(np + slip);
					slip += penalty;
				end
				slot.id = last_id;
				slot.pages = pages;
				slot.computer = comp;
				slot.prio = np;
				jobs.insert(pos, slot);
				r.accepted = 1'b1;
				r.assigned_id = last_id;
			end
		end else if (ticks_left != 0) begin
			ticks_left--;
			dv = (tpp == 0) ? 1 : tpp;
			pg = ticks_left / dv + 1;
			r.printing = 1'b1;
			r.page_number = (pg > 255) ? 8'd255 : pg[7:0];
			r.current_pages = cur_pages;
		end else begin
			if (cur_id != 0) begin
				r.done_valid = 1'b1;
				r.done_id = cur_id;
				cur_id = '0;
			end
			if (jobs.size() > 0) begin
				slot = jobs.pop_front();
				cur_id = slot.id;
				cur_pages = slot.pages;
				cur_computer = slot.computer;
				ticks_left = 16'(slot.pages * tpp);
				r.started_valid = 1'b1;
				r.started_id = slot.id;
				r.started_computer = slot.computer;
			end
		end
		r.queue_count = 5'(jobs.size());
		due_results.push_back(r);
	endtask

	task automatic compare_result();
		sched_result_t e, a;
		a.accepted = out_ch.accepted;
		a.assigned_id = out_ch.assigned_id;
		a.queue_full = out_ch.queue_full;
		a.done_valid = out_ch.done_valid;
		a.done_id = out_ch.done_id;
		a.started_valid = out_ch.started_valid;
		a.started_id = out_ch.started_id;
		a.started_computer = out_ch.started_computer;
		a.printing = out_ch.printing;
		a.page_number = out_ch.page_number;
		a.current_pages = out_ch.current_pages;
		a.queue_count = out_ch.queue_count;
		if (due_results.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected result %p", $time, a);
		end else begin
			e = due_results.pop_front();
			if (a !== e) begin
				fail_count++;
				$display("%0t: expected %p actual %p", $time, e, a);
			end
		end
	endtask

	assign pending = due_results.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jobs.delete();
			due_results.delete();
			cur_id <= '0;
			cur_pages <= '0;
			cur_computer <= '0;
			ticks_left <= '0;
			last_id <= '0;
			tpp <= TPP_RESET;
			penalty <= PENALTY_RESET;
			slack <= SLACK_RESET;
			fail_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_TPP: tpp = cfg.data[7:0];
					REG_PENALTY: penalty = cfg.data[7:0];
					REG_SLACK: slack = cfg.data;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				compare_result();
			end
			if (in_ch.valid && in_ch.ready) begin
				schedule_request(in_ch.command, in_ch.job_computer, in_ch.job_pages);
			end
		end
	end
endmodule

[tb/tb_print_job_aging_scheduler_unit.sv]
// Top of the scheduler testbench: clock, reset, request and register stimulus, verdict.
// Depends on pjas_pkg, the RTL channel interfaces, pjas_checker and the block.
`timescale 1ns / 1ps
module tb_print_job_aging_scheduler_unit
	import pjas_pkg::*;
;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;

	pjas_in_if in_ch();
	pjas_out_if out_ch();
	pjas_cfg_if cfg();

	print_job_aging_scheduler_unit dut(.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .cfg(cfg));

	pjas_checker chk(.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
		.fail_count(fail_count), .pending(pending));

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_TICK;
		in_ch.job_computer = '0;
		in_ch.job_pages = 8'd1;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_TPP;
		cfg.data = '0;
	end

	// The receiver cycles through full speed, light stalls and heavy stalls.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) begin
			stall_mode <= $urandom_range(0, 2);
		end
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= ($urandom_range(0, 3) != 0);
			default: out_ch.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// The first edge lets the checker record the last accepted request.
	task automatic settle();
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	// Sends one request, with the sender idling in random bursts and gaps.
	task automatic send_request(logic cmd, logic [3:0] comp, logic [7:0] pages);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
		end
		while (gap_left > 0) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.job_computer <= comp;
		in_ch.job_pages <= pages;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic run_phase(int count, int tick_pct, int max_pages);
		int n;
		logic [7:0] pg;
		for (n = 0; n < count; n++) begin
			pg = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255))
				: 8'($urandom_range(1, max_pages));
			send_request(($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_SUBMIT,
				4'($urandom_range(0, 15)), pg);
		end
		in_ch.valid <= 1'b0;
		settle();
	endtask

	initial begin
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: fill past full with extreme fields, then follow with six ticks.
		send_request(CMD_SUBMIT, 4'd0, 8'd1);
		send_request(CMD_SUBMIT, 4'd15, 8'd255);
		send_request(CMD_SUBMIT, 4'd5, 8'd170);
		for (k = 0; k < 14; k++) begin
			send_request(CMD_SUBMIT, 4'(k), 8'(85 + k));
		end
		for (k = 0; k < 6; k++) begin
			send_request(CMD_TICK, 4'd10, 8'd1);
		end
		in_ch.valid <= 1'b0;
		settle();
		// Extreme settings: zero ticks per page and penalty, large slack.
		write_reg(REG_TPP, 16'd0);
		write_reg(REG_PENALTY, 16'd0);
		write_reg(REG_SLACK, 16'hffff);
		run_phase(150, 50, 4);
		write_reg(REG_TPP, 16'd255);
		write_reg(REG_PENALTY, 16'd255);
		write_reg(REG_SLACK, 16'd0);
		run_phase(250, 45, 255);
		write_reg(REG_TPP, 16'd1);
		write_reg(REG_PENALTY, 16'd1);
		write_reg(REG_SLACK, 16'd0);
		run_phase(300, 55, 8);
		write_reg(REG_TPP, 16'd2);
		write_reg(REG_PENALTY, 16'd200);
		write_reg(REG_SLACK, 16'd500);
		run_phase(300, 50, 6);
		for (k = 0; k < 3; k++) begin
			write_reg(REG_TPP, 16'($urandom_range(1, 4)));
			write_reg(REG_PENALTY, 16'($urandom_range(0, 255)));
			write_reg(REG_SLACK, 16'($urandom_range(0, 65535)));
			run_phase(200, $urandom_range(40, 70), 10);
		end
		if (fail_count == 0) begin
			$display("print_job_aging_scheduler_unit regression: pass");
		end else begin
			$display("print_job_aging_scheduler_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("print_job_aging_scheduler_unit regression: fail");
		$finish;
	end
endmodule

[filelist.f]
rtl/core/pjas_pkg.sv
rtl/core/pjas_ifs.sv
rtl/core/pjas_ctrl.sv
rtl/core/pjas_dp.sv
rtl/core/print_job_aging_scheduler_unit.sv
tb/pjas_tb_ifs_note.sv
tb/pjas_checker.sv
tb/tb_print_job_aging_scheduler_unit.sv
